/* rtl/ssht_pkg.sv */
// ----------------------------------------------------------------------------
// ssht_pkg: shared types and constants of the sweep segment hit test
// Fixed-point widths derived from the coordinate width, result formats,
// register map and the bundles that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package ssht_pkg;

	localparam int COORD_BITS = 24;

	// Differences of two coordinates, their products and sums.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SQS_W  = 2 * COORD_BITS + 1;
	localparam int X_W    = 2 * COORD_BITS + 1;
	localparam int XL_W   = X_W / 2;
	localparam int XH_W   = X_W - XL_W;
	localparam int SQ_W   = 2 * X_W;

	// Squared distances are unsigned Q29.20.
	localparam int DIST_W = 49;
	localparam int CMP_W  = (SQS_W > DIST_W) ? SQS_W : DIST_W;
	localparam int R_W    = SQS_W + 1;

	// Four arithmetic stages, squaring, sum, range check, one divider
	// stage per quotient bit, lane select and output register.
	localparam int PIPE_LAT = 7 + DIST_W + 2;

	localparam int ADDR_W      = 4;
	localparam int REG_SEL_BIT = 3;
	localparam int DATA_W      = 64;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic [SQS_W-1:0]             sqs_t;
	typedef logic [X_W-1:0]               absx_t;
	typedef logic [SQ_W-1:0]              sq_t;
	typedef logic [DIST_W-1:0]            dist_t;

	localparam dist_t DIST_MAX = '1;

	localparam dist_t POINT_RADIUS_RST   = dist_t'(1509949);
	localparam dist_t SEGMENT_RADIUS_RST = dist_t'(377487);

	typedef enum logic {
		REG_POINT_RADIUS   = 1'b0,
		REG_SEGMENT_RADIUS = 1'b1
	} reg_sel_t;

	typedef enum logic {
		OP_POINT   = 1'b0,
		OP_SEGMENT = 1'b1
	} op_t;

	// Per lane bundle that rides along with the quotient.
	typedef struct packed {
		logic  use_end;
		logic  sat;
		dist_t endval;
	} side_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic crossing;
	} ctrl_t;

	function automatic dist_t sat_dist(sqs_t v);
		return (CMP_W'(v) > CMP_W'(DIST_MAX)) ? DIST_MAX : dist_t'(v);
	endfunction

endpackage

/* rtl/ssht_div.sv */
// ----------------------------------------------------------------------------
// ssht_div: pipelined restoring divider
// Produces floor(sq / len2) one quotient bit per stage. The caller makes sure
// that the quotient fits the distance width; other lanes of data ride along.
// ----------------------------------------------------------------------------
module ssht_div (
	input  logic             clk,
	input  ssht_pkg::sq_t    sq_in,
	input  ssht_pkg::sqs_t   len2_in,
	input  ssht_pkg::side_t  side_in,
	output ssht_pkg::dist_t  q_out,
	output ssht_pkg::side_t  side_out
);
	import ssht_pkg::*;

	typedef logic [R_W-1:0] rem_t;

	rem_t  rem_s  [1:DIST_W-1];
	dist_t low_s  [1:DIST_W-1];
	sqs_t  len_s  [1:DIST_W-1];
	dist_t quo_s  [1:DIST_W];
	side_t side_s [1:DIST_W];

	for (genvar k = 0; k < DIST_W; k++) begin : g_step
		rem_t  rem_cur;
		rem_t  shifted;
		rem_t  len_ext;
		dist_t low_cur;
		dist_t quo_cur;
		sqs_t  len_cur;
		side_t side_cur;
		logic  ge;

		if (k == 0) begin : g_first
			// The upper part of the dividend is below len2 whenever the result is used.
			assign rem_cur  = R_W'(sq_in[SQ_W-1:DIST_W]);
			assign low_cur  = sq_in[DIST_W-1:0];
			assign quo_cur  = '0;
			assign len_cur  = len2_in;
			assign side_cur = side_in;
		end else begin : g_next
			assign rem_cur  = rem_s[k];
			assign low_cur  = low_s[k];
			assign quo_cur  = quo_s[k];
			assign len_cur  = len_s[k];
			assign side_cur = side_s[k];
		end

		assign len_ext = R_W'(len_cur);
		assign shifted = {rem_cur[R_W-2:0], low_cur[DIST_W-1]};
		assign ge      = shifted >= len_ext;

		always_ff @(posedge clk) begin
			quo_s[k+1]  <= {quo_cur[DIST_W-2:0], ge};
			side_s[k+1] <= side_cur;
		end

		if (k < DIST_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? (shifted - len_ext) : shifted;
				low_s[k+1] <= {low_cur[DIST_W-2:0], 1'b0};
				len_s[k+1] <= len_cur;
			end
		end
	end

	assign q_out    = quo_s[DIST_W];
	assign side_out = side_s[DIST_W];

endmodule

/* rtl/sweep_segment_hit_test_unit.sv */
// ----------------------------------------------------------------------------
// sweep_segment_hit_test_unit: squared distance and hit test, 2D
// Squared distance from a point or a segment to a sweep segment, with the
// crossing test for segment targets and the radius compare for the hit flag.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy never rises.
// Each request gives one result, shown with done for one cycle, in request
// order. The result passes seven arithmetic stages and then the divider that
// forms the interior projection distance, one quotient bit per stage. The
// radius registers are written through the APB port at byte addresses 0 and 8.
module sweep_segment_hit_test_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  ssht_pkg::coord_t              sweep_start_x,
	input  ssht_pkg::coord_t              sweep_start_y,
	input  ssht_pkg::coord_t              sweep_end_x,
	input  ssht_pkg::coord_t              sweep_end_y,
	input  ssht_pkg::coord_t              target_a_x,
	input  ssht_pkg::coord_t              target_a_y,
	input  ssht_pkg::coord_t              target_b_x,
	input  ssht_pkg::coord_t              target_b_y,
	output logic                          done,
	output ssht_pkg::dist_t               dist_sq,
	output logic                          hit,
	output logic                          crossing,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssht_pkg::ADDR_W-1:0]   paddr,
	input  logic [ssht_pkg::DATA_W-1:0]   pwdata,
	output logic [ssht_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ssht_pkg::*;

	typedef struct packed {
		diff_t x;
		diff_t y;
	} vec_t;

	typedef struct packed {
		prod_t p;
		prod_t q;
	} pair_t;

	function automatic prod_t mul(diff_t a, diff_t b);
		return a * b;
	endfunction

	function automatic sqs_t sqsum(pair_t v);
		prod_t s;
		s = v.p + v.q;
		return s[SQS_W-1:0];
	endfunction

	function automatic logic in_box(coord_t px, coord_t py, coord_t ax, coord_t ay,
			coord_t bx, coord_t by);
		logic ix;
		logic iy;
		ix = (ax < bx) ? (px >= ax && px <= bx) : (px >= bx && px <= ax);
		iy = (ay < by) ? (py >= ay && py <= by) : (py >= by && py <= ay);
		return ix && iy;
	endfunction

	function automatic logic opposite(prod_t a, prod_t b);
		return (a != '0) && (b != '0) && (a[PROD_W-1] != b[PROD_W-1]);
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	dist_t    point_radius_q;
	dist_t    segment_radius_q;
	reg_sel_t reg_sel;
	logic     cfg_wr;

	assign reg_sel = reg_sel_t'(paddr[REG_SEL_BIT]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_radius_q   <= POINT_RADIUS_RST;
			segment_radius_q <= SEGMENT_RADIUS_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_POINT_RADIUS:   point_radius_q   <= pwdata[DIST_W-1:0];
				REG_SEGMENT_RADIUS: segment_radius_q <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_POINT_RADIUS:   prdata = DATA_W'(point_radius_q);
			REG_SEGMENT_RADIUS: prdata = DATA_W'(segment_radius_q);
			default:            prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: coordinate differences and bounding box tests.
	// Lane 0 is sweep start against the target segment, lane 1 sweep end,
	// lane 2 the first target point and lane 3 the second, both against
	// the sweep segment. Point mode uses lane 2.
	// ------------------------------------------------------------------
	ctrl_t      ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6, ctrl_s7;
	ctrl_t      ctrl_div_s [DIST_W];
	ctrl_t      ctrl_m1;
	vec_t       u_s1, v_s1, ca_s1, da_s1, cb_s1, db_s1;
	logic [3:0] bb_s1, bb_s2, bb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid    <= start && !busy;
			ctrl_s1.op       <= op_t'(op);
			ctrl_s1.crossing <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		u_s1.x  <= sweep_end_x - sweep_start_x;
		u_s1.y  <= sweep_end_y - sweep_start_y;
		v_s1.x  <= target_b_x - target_a_x;
		v_s1.y  <= target_b_y - target_a_y;
		ca_s1.x <= target_a_x - sweep_start_x;
		ca_s1.y <= target_a_y - sweep_start_y;
		da_s1.x <= target_b_x - sweep_start_x;
		da_s1.y <= target_b_y - sweep_start_y;
		cb_s1.x <= target_a_x - sweep_end_x;
		cb_s1.y <= target_a_y - sweep_end_y;
		db_s1.x <= target_b_x - sweep_end_x;
		db_s1.y <= target_b_y - sweep_end_y;
		bb_s1[0] <= in_box(sweep_start_x, sweep_start_y, target_a_x, target_a_y,
			target_b_x, target_b_y);
		bb_s1[1] <= in_box(sweep_end_x, sweep_end_y, target_a_x, target_a_y,
			target_b_x, target_b_y);
		bb_s1[2] <= in_box(target_a_x, target_a_y, sweep_start_x, sweep_start_y,
			sweep_end_x, sweep_end_y);
		bb_s1[3] <= in_box(target_b_x, target_b_y, sweep_start_x, sweep_start_y,
			sweep_end_x, sweep_end_y);
	end

	// ------------------------------------------------------------------
	// Stage 2: all products of differences.
	// ------------------------------------------------------------------
	pair_t lab_s2, lcd_s2, dca_s2, dda_s2, dcb_s2, ddb_s2;
	pair_t dot_s2 [4];
	pair_t crs_s2 [4];

	always_ff @(posedge clk) begin
		lab_s2    <= '{mul(u_s1.x, u_s1.x), mul(u_s1.y, u_s1.y)};
		lcd_s2    <= '{mul(v_s1.x, v_s1.x), mul(v_s1.y, v_s1.y)};
		dca_s2    <= '{mul(ca_s1.x, ca_s1.x), mul(ca_s1.y, ca_s1.y)};
		dda_s2    <= '{mul(da_s1.x, da_s1.x), mul(da_s1.y, da_s1.y)};
		dcb_s2    <= '{mul(cb_s1.x, cb_s1.x), mul(cb_s1.y, cb_s1.y)};
		ddb_s2    <= '{mul(db_s1.x, db_s1.x), mul(db_s1.y, db_s1.y)};
		dot_s2[0] <= '{mul(ca_s1.x, v_s1.x), mul(ca_s1.y, v_s1.y)};
		dot_s2[1] <= '{mul(cb_s1.x, v_s1.x), mul(cb_s1.y, v_s1.y)};
		dot_s2[2] <= '{mul(ca_s1.x, u_s1.x), mul(ca_s1.y, u_s1.y)};
		dot_s2[3] <= '{mul(da_s1.x, u_s1.x), mul(da_s1.y, u_s1.y)};
		crs_s2[0] <= '{mul(v_s1.y, ca_s1.x), mul(v_s1.x, ca_s1.y)};
		crs_s2[1] <= '{mul(v_s1.y, cb_s1.x), mul(v_s1.x, cb_s1.y)};
		crs_s2[2] <= '{mul(u_s1.x, ca_s1.y), mul(u_s1.y, ca_s1.x)};
		crs_s2[3] <= '{mul(u_s1.x, da_s1.y), mul(u_s1.y, da_s1.x)};
		bb_s2     <= bb_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: lengths, endpoint distances, dot and cross products per lane.
	// The lanes against the target segment measure from its first end, so
	// their dot products change sign.
	// ------------------------------------------------------------------
	sqs_t  len_s3 [4];
	sqs_t  st_s3  [4];
	sqs_t  en_s3  [4];
	prod_t dot_s3 [4];
	prod_t x_s3   [4];

	always_ff @(posedge clk) begin
		len_s3[0] <= sqsum(lcd_s2);
		len_s3[1] <= sqsum(lcd_s2);
		len_s3[2] <= sqsum(lab_s2);
		len_s3[3] <= sqsum(lab_s2);
		st_s3[0]  <= sqsum(dca_s2);
		st_s3[1]  <= sqsum(dcb_s2);
		st_s3[2]  <= sqsum(dca_s2);
		st_s3[3]  <= sqsum(dda_s2);
		en_s3[0]  <= sqsum(dda_s2);
		en_s3[1]  <= sqsum(ddb_s2);
		en_s3[2]  <= sqsum(dcb_s2);
		en_s3[3]  <= sqsum(ddb_s2);
		dot_s3[0] <= -dot_s2[0].p - dot_s2[0].q;
		dot_s3[1] <= -dot_s2[1].p - dot_s2[1].q;
		dot_s3[2] <= dot_s2[2].p + dot_s2[2].q;
		dot_s3[3] <= dot_s2[3].p + dot_s2[3].q;
		for (int l = 0; l < 4; l++) begin
			x_s3[l] <= crs_s2[l].p - crs_s2[l].q;
		end
		bb_s3 <= bb_s2;
	end

	// ------------------------------------------------------------------
	// Stage 4: crossing test and projection case per lane.
	// ------------------------------------------------------------------
	logic  cross_c;
	logic  use_end_c [4];
	dist_t endval_c  [4];
	absx_t absx_c    [4];

	always_comb begin
		cross_c = (opposite(x_s3[2], x_s3[3]) && opposite(x_s3[0], x_s3[1]));
		for (int l = 0; l < 4; l++) begin
			cross_c = cross_c || ((x_s3[l] == '0) && bb_s3[l]);
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_case
		prod_t neg_x;
		assign neg_x = -x_s3[l];

		always_comb begin
			// A zero length or a projection at or before the start uses the start.
			if (len_s3[l] == '0 || dot_s3[l][PROD_W-1] || dot_s3[l] == '0) begin
				use_end_c[l] = 1'b1;
				endval_c[l]  = sat_dist(st_s3[l]);
			end else if (dot_s3[l][SQS_W-1:0] >= len_s3[l]) begin
				use_end_c[l] = 1'b1;
				endval_c[l]  = sat_dist(en_s3[l]);
			end else begin
				use_end_c[l] = 1'b0;
				endval_c[l]  = sat_dist(st_s3[l]);
			end
			absx_c[l] = x_s3[l][PROD_W-1] ? neg_x[X_W-1:0] : x_s3[l][X_W-1:0];
		end
	end

	side_t side_s4 [4];
	absx_t absx_s4 [4];
	sqs_t  len_s4  [4];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			side_s4[l] <= '{use_end_c[l], 1'b0, endval_c[l]};
			absx_s4[l] <= absx_c[l];
			len_s4[l]  <= len_s3[l];
		end
	end

	// ------------------------------------------------------------------
	// Stages 5 to 7: square of the cross product in partial products, their
	// sum, and the check that the quotient fits.
	// ------------------------------------------------------------------
	logic [2*XH_W-1:0]      hh_s5 [4];
	logic [XH_W+XL_W-1:0]   hl_s5 [4];
	logic [2*XL_W-1:0]      ll_s5 [4];
	side_t                  side_s5 [4], side_s6 [4], side_s7 [4];
	sqs_t                   len_s5 [4], len_s6 [4], len_s7 [4];
	sq_t                    sq_s6 [4], sq_s7 [4];
	dist_t                  quo_d [4];
	side_t                  side_d [4];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [XH_W-1:0] xh;
		logic [XL_W-1:0] xl;

		assign xh = absx_s4[l][X_W-1:XL_W];
		assign xl = absx_s4[l][XL_W-1:0];

		always_ff @(posedge clk) begin
			hh_s5[l]   <= xh * xh;
			hl_s5[l]   <= xh * xl;
			ll_s5[l]   <= xl * xl;
			side_s5[l] <= side_s4[l];
			len_s5[l]  <= len_s4[l];

			sq_s6[l]   <= (SQ_W'(hh_s5[l]) << (2 * XL_W)) + (SQ_W'(hl_s5[l]) << (XL_W + 1))
				+ SQ_W'(ll_s5[l]);
			side_s6[l] <= side_s5[l];
			len_s6[l]  <= len_s5[l];

			sq_s7[l]   <= sq_s6[l];
			len_s7[l]  <= len_s6[l];
			side_s7[l] <= '{side_s6[l].use_end, sq_s6[l][SQ_W-1:DIST_W] >= len_s6[l],
				side_s6[l].endval};
		end

		ssht_div u_div (
			.clk      (clk),
			.sq_in    (sq_s7[l]),
			.len2_in  (len_s7[l]),
			.side_in  (side_s7[l]),
			.q_out    (quo_d[l]),
			.side_out (side_d[l])
		);
	end

	// ------------------------------------------------------------------
	// Control travels alongside the lanes.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
			for (int i = 0; i < DIST_W; i++) begin
				ctrl_div_s[i] <= '0;
			end
			ctrl_m1 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= '{ctrl_s3.valid, ctrl_s3.op, cross_c && (ctrl_s3.op == OP_SEGMENT)};
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
			ctrl_div_s[0] <= ctrl_s7;
			for (int i = 1; i < DIST_W; i++) begin
				ctrl_div_s[i] <= ctrl_div_s[i-1];
			end
			ctrl_m1 <= ctrl_div_s[DIST_W-1];
		end
	end

	// ------------------------------------------------------------------
	// Lane select, minimum over lanes and the radius compare.
	// ------------------------------------------------------------------
	dist_t lane_c [4];
	dist_t pt_m1, min01_m1, min23_m1;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (side_d[l].use_end) begin
				lane_c[l] = side_d[l].endval;
			end else if (side_d[l].sat) begin
				lane_c[l] = DIST_MAX;
			end else begin
				lane_c[l] = quo_d[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		pt_m1    <= lane_c[2];
		min01_m1 <= (lane_c[1] < lane_c[0]) ? lane_c[1] : lane_c[0];
		min23_m1 <= (lane_c[3] < lane_c[2]) ? lane_c[3] : lane_c[2];
	end

	dist_t res_c;
	dist_t radius_c;

	always_comb begin
		case (ctrl_m1.op)
			OP_SEGMENT: begin
				radius_c = segment_radius_q;
				if (ctrl_m1.crossing) begin
					res_c = '0;
				end else begin
					res_c = (min23_m1 < min01_m1) ? min23_m1 : min01_m1;
				end
			end
			default: begin
				radius_c = point_radius_q;
				res_c    = pt_m1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_m1.valid;
		end
	end

	always_ff @(posedge clk) begin
		dist_sq  <= res_c;
		hit      <= res_c <= radius_c;
		crossing <= ctrl_m1.crossing;
	end

`ifndef ASSERT_OFF
	// Every request comes out after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("request did not complete after the pipeline latency");

	// A crossing result is a zero distance and always a hit.
	a_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && crossing) |-> (dist_sq == '0 && hit))
		else $error("crossing result without zero distance and hit");
`endif

endmodule
